// ===== hdl/lasr_pkg.sv =====
// ----------------------------------------------------------------------------
// lasr_pkg: shared types and codes for the list append/search/reverse block
// Command and result codes, field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package lasr_pkg;

    // field widths
    localparam int ACT_W  = 2;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;

    // command codes
    localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ELEMENT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;

    // cell operations
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_DOWN  = 2'd1;  // take the value of the cell above
    localparam logic [1:0] OP_UP    = 2'd2;  // take the value of the cell below
    localparam logic [1:0] OP_WRITE = 2'd3;  // selected cell loads the new value

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

// ===== hdl/lasr_if.sv =====
// ----------------------------------------------------------------------------
// lasr_if: handshake channels of the list block
// Command channel (action, value) and result channel (kind, value, position,
// last); valid/ready, an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface lasr_cmd_if;
    import lasr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface lasr_res_if;
    import lasr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic                    last;

    modport source (output valid, kind, item_value, position, last, input ready);
    modport sink   (input valid, kind, item_value, position, last, output ready);
endinterface

// ===== hdl/lasr_cell.sv =====
// ----------------------------------------------------------------------------
// lasr_cell: one storage cell of the list ring
// Holds one entry; shifts toward either neighbor or loads a written value.
// ----------------------------------------------------------------------------
module lasr_cell
(
    input  logic                             clk,
    input  lasr_pkg::cell_ctl_t              ctl,
    input  logic                             wr_sel,
    input  logic signed [lasr_pkg::VAL_W-1:0] prev_val,
    input  logic signed [lasr_pkg::VAL_W-1:0] next_val,
    output logic signed [lasr_pkg::VAL_W-1:0] q
);
    import lasr_pkg::*;

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    // next entry value
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_DOWN:  data_next = next_val;
            OP_UP:    data_next = prev_val;
            OP_WRITE:
            begin
                if (wr_sel)
                begin
                    data_next = ctl.value;
                end
            end
            default:  data_next = data_reg;
        endcase
    end

    // entry storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== hdl/list_append_search_reverse.sv =====
// ----------------------------------------------------------------------------
// list_append_search_reverse: ordered list of signed 32-bit values
// Append, search and reverse-and-dump over a ring of DEPTH storage cells.
// ----------------------------------------------------------------------------
// The list lives in a ring of DEPTH cells; a direction flag picks whether the
// head is cell 0 or cell count-1. An append is a plain write, or a one-step
// shift of the whole ring when the list is reversed, and gives no result
// unless the list is full. Search and a reverse of a non-empty list walk the
// list by rotating the ring one cell per cycle (a reverse stalls while its
// element waits for a busy result slot) and reading a fixed tap, always for a
// full DEPTH steps so the ring is back in place at the end; a search gives
// one result at its end. Commands are taken only while no walk is running and
// no final result waits; one waiting result does not block the next command.
// ----------------------------------------------------------------------------
module list_append_search_reverse #(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    lasr_cmd_if.sink    cmd,
    lasr_res_if.source  res
);
    import lasr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // control state
    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    rev_reg, rev_next;
    logic [IW-1:0]           step_reg, step_next;
    logic                    search_reg, search_next;
    logic                    found_reg, found_next;
    logic                    ov_reg, ov_next;

    // payload registers
    logic [POS_W-1:0]        fpos_reg, fpos_next;
    logic signed [VAL_W-1:0] sval_reg, sval_next;
    logic [KIND_W-1:0]       fkind_reg, fkind_next;
    logic [POS_W-1:0]        fin_pos_reg, fin_pos_next;
    logic [KIND_W-1:0]       okind_reg, okind_next;
    logic signed [VAL_W-1:0] oval_reg, oval_next;
    logic [POS_W-1:0]        opos_reg, opos_next;
    logic                    olast_reg, olast_next;

    // cell ring
    cell_ctl_t               ctl;
    logic signed [VAL_W-1:0] prev0;
    logic signed [VAL_W-1:0] cell_q [DEPTH];

    // walk datapath
    logic                    accept;
    logic                    slot_free;
    logic signed [VAL_W-1:0] tap_val;
    logic [CW-1:0]           step_ext;
    logic [CW-1:0]           lpos;
    logic [POS_W-1:0]        lpos_p;
    logic                    in_range;
    logic                    hit;
    logic                    emit_el;
    logic                    advance;
    logic                    last_step;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign slot_free = !ov_reg || res.ready;

    // read tap: cell 0 when walking down, top cell when walking up
    assign tap_val   = rev_reg ? cell_q[DEPTH-1] : cell_q[0];
    assign step_ext  = CW'(step_reg);
    assign in_range  = rev_reg ? (step_ext >= (DEPTH_C - count_reg))
                               : (step_ext < count_reg);
    assign lpos      = rev_reg ? (step_ext - (DEPTH_C - count_reg)) : step_ext;
    assign lpos_p    = POS_W'(lpos);
    assign hit       = in_range && (tap_val == sval_reg);
    assign last_step = (step_reg == LAST_STEP);
    assign emit_el   = (state_reg == ST_WALK) && !search_reg && in_range;
    assign advance   = (state_reg == ST_WALK) && (!emit_el || slot_free);

    // ring control
    always_comb
    begin
        ctl.op    = OP_HOLD;
        ctl.value = cmd.value;
        prev0     = cell_q[DEPTH-1];
        if (accept && (cmd.action == ACT_APPEND) && (count_reg < DEPTH_C))
        begin
            if (rev_reg)
            begin
                // tail sits in cell 0: shift everything up and insert
                ctl.op = OP_UP;
                prev0  = cmd.value;
            end
            else
            begin
                ctl.op = OP_WRITE;
            end
        end
        else if (advance)
        begin
            ctl.op = rev_reg ? OP_UP : OP_DOWN;
        end
    end

    // cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [VAL_W-1:0] prev_v;
            logic signed [VAL_W-1:0] next_v;

            if (gi == 0)
            begin : g_first
                assign prev_v = prev0;
            end
            else
            begin : g_mid
                assign prev_v = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_top
                assign next_v = cell_q[0];
            end
            else
            begin : g_low
                assign next_v = cell_q[gi+1];
            end

            lasr_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .wr_sel   (count_reg == CW'(gi)),
                .prev_val (prev_v),
                .next_val (next_v),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        step_next    = step_reg;
        search_next  = search_reg;
        found_next   = found_reg;
        fpos_next    = fpos_reg;
        sval_next    = sval_reg;
        fkind_next   = fkind_reg;
        fin_pos_next = fin_pos_reg;
        ov_next      = ov_reg && !res.ready;
        okind_next   = okind_reg;
        oval_next    = oval_reg;
        opos_next    = opos_reg;
        olast_next   = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_APPEND:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                fkind_next   = KIND_FULL;
                                fin_pos_next = '0;
                                state_next   = ST_FIN;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            sval_next   = cmd.value;
                            search_next = 1'b1;
                            found_next  = 1'b0;
                            step_next   = '0;
                            state_next  = ST_WALK;
                        end
                        ACT_REVERSE:
                        begin
                            rev_next = !rev_reg;
                            if (count_reg == '0)
                            begin
                                fkind_next   = KIND_EMPTY;
                                fin_pos_next = '0;
                                state_next   = ST_FIN;
                            end
                            else
                            begin
                                search_next = 1'b0;
                                step_next   = '0;
                                state_next  = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (advance)
                begin
                    step_next = step_reg + 1'b1;
                    // first match of a search
                    if (search_reg && hit && !found_reg)
                    begin
                        found_next = 1'b1;
                        fpos_next  = lpos_p;
                    end
                    // element out of a reverse
                    if (emit_el)
                    begin
                        ov_next    = 1'b1;
                        okind_next = KIND_ELEMENT;
                        oval_next  = tap_val;
                        opos_next  = lpos_p;
                        olast_next = (lpos == (count_reg - 1'b1));
                    end
                    if (last_step)
                    begin
                        step_next = '0;
                        if (search_reg)
                        begin
                            if (found_reg)
                            begin
                                fkind_next   = KIND_FOUND;
                                fin_pos_next = fpos_reg;
                            end
                            else if (hit)
                            begin
                                fkind_next   = KIND_FOUND;
                                fin_pos_next = lpos_p;
                            end
                            else
                            begin
                                fkind_next   = KIND_NOT_FOUND;
                                fin_pos_next = '0;
                            end
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = fkind_reg;
                    oval_next  = '0;
                    opos_next  = fin_pos_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            step_reg   <= '0;
            search_reg <= 1'b0;
            found_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            step_reg   <= step_next;
            search_reg <= search_next;
            found_reg  <= found_next;
            ov_reg     <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fpos_reg    <= fpos_next;
        sval_reg    <= sval_next;
        fkind_reg   <= fkind_next;
        fin_pos_reg <= fin_pos_next;
        okind_reg   <= okind_next;
        oval_reg    <= oval_next;
        opos_reg    <= opos_next;
        olast_reg   <= olast_next;
    end

    // result port
    assign res.valid      = ov_reg;
    assign res.kind       = okind_reg;
    assign res.item_value = oval_reg;
    assign res.position   = opos_reg;
    assign res.last       = olast_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("list count beyond depth");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("walk step not cleared at idle");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.action == ACT_APPEND) && (count_reg != DEPTH_C))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the list");

    a_reverse_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.action == ACT_REVERSE)) |=> (rev_reg != $past(rev_reg)))
        else $error("reverse did not flip direction");

endmodule
